// ===== rtl/core/piecewise_linear_limiter_unit_assert.svh =====
// Assertion macros for the piecewise-linear limiter blocks.
`ifndef PIECEWISE_LINEAR_LIMITER_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_LIMITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PLU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plu assertion failed");
`define PLU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plu assertion failed");
`else
`define PLU_ASSERT_IMP(name, ante, cons)
`define PLU_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/core/plu_pkg.sv =====
// Shared constants, register codes and pipeline types of the limiter.
`default_nettype none

package plu_pkg;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [MODE_W-1:0] MODE_LINE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VALUE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PERCENT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_THREE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MINMAX  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP0_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BP2_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BP0_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BP1_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BP2_Y = 3'd6;

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};
  localparam logic [DW-1:0] BP1_X_RST = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic signed [DW-1:0]   bp0_x;
    logic signed [DW-1:0]   bp1_x;
    logic signed [DW-1:0]   bp2_x;
    logic signed [DW-1:0]   bp0_y;
    logic signed [DW-1:0]   bp1_y;
    logic signed [DW-1:0]   bp2_y;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0]        rem;
    logic [DW-1:0]        den;
    logic [FB-1:0]        quot;
    logic signed [DW-1:0] ya;
    logic signed [DW:0]   dy;
    logic                 full;
    logic                 sat;
  } div_t;

  function automatic logic signed [DW:0] sext1(input logic signed [DW-1:0] a);
    return {a[DW-1], a};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/plu_prep.sv =====
// Front stages: mode decode, segment setup, gain product and divider operands.
`default_nettype none

module plu_prep import plu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output div_t                 out_data
);

  logic signed [DW-1:0]   x, b0x, b1x, b2x, b0y, b1y, b2y;
  logic signed [DW-1:0]   lo, hi, xc, dir_c, ya_c, yb_c;
  logic signed [DW:0]     num_c, den_c;
  logic signed [2*DW-1:0] prod_c;
  logic                   sel_lo, interp_c;

  logic                   s1_valid, s1_interp, s1_pct;
  logic signed [DW:0]     s1_num, s1_den, s1_dy;
  logic signed [DW-1:0]   s1_ya, s1_zy, s1_dir;
  logic signed [2*DW-1:0] s1_prod;
  logic                   s1_ready, s2_ready;

  logic                     zero_den, num_neg, den_neg, t_zero, full, p_hi, p_lo;
  logic [DW:0]              n_full, d_full;
  logic [DW-1:0]            n_mag, d_mag;
  logic signed [2*DW-FB-1:0] p_sh;
  div_t                     s2_next;

  always_comb begin
    x   = sample;
    b0x = cfg.bp0_x;
    b1x = cfg.bp1_x;
    b2x = cfg.bp2_x;
    b0y = cfg.bp0_y;
    b1y = cfg.bp1_y;
    b2y = cfg.bp2_y;
    lo  = (b1x < b2x) ? b1x : b2x;
    hi  = (b1x < b2x) ? b2x : b1x;
    if (x < lo) begin
      xc = lo;
    end else if (x > hi) begin
      xc = hi;
    end else begin
      xc = x;
    end
    sel_lo   = (x <= b1x);
    prod_c   = x * b1x;
    interp_c = 1'b0;
    num_c    = '0;
    den_c    = '0;
    ya_c     = b1y;
    yb_c     = b2y;
    dir_c    = x;
    unique case (cfg.mode)
      MODE_LINE: begin
        interp_c = 1'b1;
        num_c    = sext1(xc) - sext1(b1x);
        den_c    = sext1(b2x) - sext1(b1x);
      end
      MODE_THREE: begin
        interp_c = 1'b1;
        if (sel_lo) begin
          num_c = sext1(x) - sext1(b0x);
          den_c = sext1(b1x) - sext1(b0x);
          ya_c  = b0y;
          yb_c  = b1y;
        end else begin
          num_c = sext1(x) - sext1(b1x);
          den_c = sext1(b2x) - sext1(b1x);
        end
      end
      MODE_VALUE:  dir_c = b1x;
      MODE_MINMAX: begin
        if (x < b1x) begin
          dir_c = b1x;
        end else if (x > b2x) begin
          dir_c = b2x;
        end else begin
          dir_c = x;
        end
      end
      default: dir_c = x;
    endcase
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_interp <= interp_c;
      s1_pct    <= (cfg.mode == MODE_PERCENT);
      s1_num    <= num_c;
      s1_den    <= den_c;
      s1_dy     <= sext1(yb_c) - sext1(ya_c);
      s1_ya     <= ya_c;
      s1_zy     <= b1y;
      s1_dir    <= dir_c;
      s1_prod   <= prod_c;
    end
  end

  always_comb begin
    zero_den = (s1_den == '0);
    num_neg  = s1_num[DW];
    den_neg  = s1_den[DW];
    n_full   = num_neg ? (~s1_num + 1'b1) : s1_num;
    d_full   = den_neg ? (~s1_den + 1'b1) : s1_den;
    n_mag    = n_full[DW-1:0];
    d_mag    = d_full[DW-1:0];
    t_zero   = (s1_num == '0) || (num_neg != den_neg);
    full     = !t_zero && (n_mag >= d_mag);
    p_sh     = s1_prod[2*DW-1:FB];
    p_hi     = p_sh > (2*DW-FB)'(VMAX);
    p_lo     = p_sh < (2*DW-FB)'(VMIN);

    s2_next.rem  = '0;
    s2_next.den  = '0;
    s2_next.quot = '0;
    s2_next.ya   = s1_dir;
    s2_next.dy   = '0;
    s2_next.full = 1'b0;
    s2_next.sat  = 1'b0;
    priority if (s1_interp && !zero_den) begin
      s2_next.rem  = (t_zero || full) ? '0 : n_mag;
      s2_next.den  = d_mag;
      s2_next.ya   = s1_ya;
      s2_next.dy   = s1_dy;
      s2_next.full = full;
    end else if (s1_interp) begin
      s2_next.ya = s1_zy;
    end else if (s1_pct) begin
      s2_next.sat = p_hi || p_lo;
      if (p_hi) begin
        s2_next.ya = VMAX;
      end else if (p_lo) begin
        s2_next.ya = VMIN;
      end else begin
        s2_next.ya = p_sh[DW-1:0];
      end
    end else begin
      s2_next.ya = s1_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/plu_div_cell.sv =====
// One restoring-division cell: one fraction bit per cell, payload handed on.
`default_nettype none
`include "piecewise_linear_limiter_unit_assert.svh"

module plu_div_cell import plu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic [DW:0] r2, diff;
  logic        ge;
  div_t        data_next;

  always_comb begin
    r2        = {in_data.rem, 1'b0};
    diff      = r2 - {1'b0, in_data.den};
    ge        = (r2 >= {1'b0, in_data.den});
    data_next = in_data;
    data_next.rem  = ge ? diff[DW-1:0] : r2[DW-1:0];
    data_next.quot = {in_data.quot[FB-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

  `PLU_ASSERT_NXT(a_rem_below_den, in_ready && in_valid && in_data.den != '0 && in_data.rem < in_data.den, out_data.rem < out_data.den)

endmodule

`default_nettype wire

// ===== rtl/core/plu_lerp.sv =====
// Back stages: fraction times segment rise, then add to segment start.
`default_nettype none

module plu_lerp import plu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  div_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] limited,
  output logic                 saturated
);

  logic [FB:0]               t;
  logic signed [DW+FB+2:0]   prod_c;
  logic                      a_valid, a_ready, b_ready;
  logic signed [DW+FB+2:0]   a_prod;
  logic signed [DW-1:0]      a_ya;
  logic                      a_sat;

  always_comb begin
    t      = in_data.full ? ONE_Q : {1'b0, in_data.quot};
    prod_c = $signed({1'b0, t}) * in_data.dy;
  end

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_prod <= prod_c;
      a_ya   <= in_data.ya;
      a_sat  <= in_data.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      limited   <= a_ya + $signed(a_prod[DW+FB-1:FB]);
      saturated <= a_sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_linear_limiter_unit.sv =====
// Top level of the piecewise-linear limiter: registers, divide chain, output.
// An accepted sample passes 2 setup stages, 16 divide cells and 2 interpolation
// stages to its limited beat; one sample per cycle sustained while the output does not stall.
// The divide chain is a row of 16 one-bit divide cells, each a stage.
// Stalls hold per stage, so bubbles collapse and input is taken while any stage is free.
// Reset clears all valid flags and loads default register values; no clearing pass.
`default_nettype none
`include "piecewise_linear_limiter_unit_assert.svh"

module piecewise_linear_limiter_unit import plu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic signed [DW-1:0] sample,
  output logic                 limited_valid,
  input  logic                 limited_ready,
  output logic signed [DW-1:0] limited,
  output logic                 saturated
);

  cfg_t        cfg;
  logic [FB:0] v;
  logic [FB:0] r;
  div_t        d [FB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_PERCENT;
      cfg.bp0_x <= '0;
      cfg.bp1_x <= BP1_X_RST;
      cfg.bp2_x <= '0;
      cfg.bp0_y <= '0;
      cfg.bp1_y <= '0;
      cfg.bp2_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:  cfg.mode  <= cfg_data[MODE_W-1:0];
        REG_BP0_X: cfg.bp0_x <= cfg_data;
        REG_BP1_X: cfg.bp1_x <= cfg_data;
        REG_BP2_X: cfg.bp2_x <= cfg_data;
        REG_BP0_Y: cfg.bp0_y <= cfg_data;
        REG_BP1_Y: cfg.bp1_y <= cfg_data;
        REG_BP2_Y: cfg.bp2_y <= cfg_data;
        default: ;
      endcase
    end
  end

  plu_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .sample    (sample),
    .out_valid (v[0]),
    .out_ready (r[0]),
    .out_data  (d[0])
  );

  for (genvar i = 0; i < FB; i++) begin : g_cell
    plu_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_data  (d[i+1])
    );
  end

  plu_lerp u_lerp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[FB]),
    .in_ready  (r[FB]),
    .in_data   (d[FB]),
    .out_valid (limited_valid),
    .out_ready (limited_ready),
    .limited   (limited),
    .saturated (saturated)
  );

  `PLU_ASSERT_IMP(a_sat_at_rail, limited_valid && saturated, limited == VMAX || limited == VMIN)
  `PLU_ASSERT_IMP(a_stall_from_out, !sample_ready, limited_valid && !limited_ready)
  `PLU_ASSERT_NXT(a_reset_empty, rst, !limited_valid)

endmodule

`default_nettype wire
